FILE: rtl/gif_lzw_pkg.sv
// Package for the GIF LZW decoder: beat types, sizes, status and sequencer codes.
`timescale 1ns / 1ps
package gif_lzw_pkg;

	// Dictionary and unwind stack sizes
	localparam int TABLE_ENTRIES = 4096;
	localparam int STACK_DEPTH   = 4096;
	localparam int TAB_AW        = $clog2(TABLE_ENTRIES);
	localparam int STK_AW        = $clog2(STACK_DEPTH);
	localparam int RES_BYTES     = 64;

	localparam logic [3:0] DEF_MIN_WIDTH = 4'd8;

	// Result status codes
	localparam logic [1:0] STAT_DATA   = 2'd0;
	localparam logic [1:0] STAT_END    = 2'd1;
	localparam logic [1:0] STAT_BAD    = 2'd2;
	localparam logic [1:0] STAT_RANOUT = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] pixels_word0;
		logic [63:0] pixels_word1;
		logic [63:0] pixels_word2;
		logic [63:0] pixels_word3;
		logic [63:0] pixels_word4;
		logic [63:0] pixels_word5;
		logic [63:0] pixels_word6;
		logic [63:0] pixels_word7;
		logic [6:0]  byte_count;
		logic [1:0]  status;
		logic        last;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXTRACT,
		ST_CODE,
		ST_WALK_RD,
		ST_WALK_USE,
		ST_POP_RD,
		ST_POP_USE,
		ST_FINAL
	} seq_state_t;

endpackage

FILE: rtl/gif_lzw_decoder_top.sv
// GIF LZW decoder top level: bit unpacker, dictionary walk sequencer and result packer.
`timescale 1ns / 1ps
// Usage:
//   Input beats (in_valid/in_stall) carry one compressed byte or an end-of-input
//   mark. Result beats (out_valid/out_stall) carry up to 64 decoded bytes, a status
//   and a last flag on the final result of each input. The cfg channel
//   (cfg_valid/cfg_ready) writes the minimum code size and reinitializes decoding;
//   it is taken only while the block is idle.
//   Sequencing: in_stall stays high while a byte is decoded. A byte is accepted, then
//   extracted step by step (one step per code it completes, one more for a trailing
//   partial code), then found used up. Each code is dispatched, then each dictionary
//   entry is walked with a read and a use state, the root byte is pushed (not right
//   after a clear), each decoded byte is popped with a read and a use state, and the
//   stack is found empty. A final result is handed over in the final state. The
//   dictionary read port sets the walk rate.
//   Results go through an output register, so a stalled receiver holds the block
//   only when a second result is ready to leave. An input that decodes no bytes gives
//   no result unless it ends decoding. After an end code, an invalid code or end of
//   input the block drops every input until the config is written again.
//   Reset: asynchronous, clears all control state; minimum code size returns to 8.
//   Dictionary and stack contents are not cleared and need no clearing pass.
module gif_lzw_decoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  gif_lzw_pkg::in_beat_t in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output gif_lzw_pkg::out_beat_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [3:0]            cfg_data
);

	localparam int TAB_AW = gif_lzw_pkg::TAB_AW;
	localparam int STK_AW = gif_lzw_pkg::STK_AW;

	function automatic logic [3:0] clamp_w(input logic [3:0] w);
		logic [3:0] r;
		r = w;
		if (w < 4'd2) r = 4'd2;
		else if (w > 4'd8) r = 4'd8;
		return r;
	endfunction

	gif_lzw_pkg::seq_state_t state_q, state_d;

	// Control and datapath registers
	logic [3:0]        min_w_q;
	logic [12:0]       nfc_q;
	logic [12:0]       limit_q;
	logic [3:0]        width_q;
	logic [7:0]        bitbuf_q;
	logic [3:0]        held_q;
	logic [11:0]       partial_q;
	logic [3:0]        pbits_q;
	logic [7:0]        first_q;
	logic [11:0]       prev_q;
	logic              after_clear_q;
	logic              halted_q;
	logic [11:0]       code_q;
	logic [11:0]       incode_q;
	logic [11:0]       k_q;
	logic [STK_AW:0]   sp_q;
	logic              add_q;
	logic [1:0]        status_q;
	logic [6:0]        cnt_q;
	logic [63:0][7:0]  obuf_q;
	logic              out_valid_q;
	gif_lzw_pkg::out_beat_t out_q;

	// Memories
	logic [19:0] dict_mem [gif_lzw_pkg::TABLE_ENTRIES];
	logic [7:0]  stk_mem  [gif_lzw_pkg::STACK_DEPTH];
	logic [19:0] dict_rd_q;
	logic [7:0]  stk_rd_q;

	// Derived values
	logic [3:0]  eff_w, cfg_eff;
	logic [12:0] clr, cfg_clr;
	logic [12:0] code_x, k_x;
	assign eff_w   = clamp_w(min_w_q);
	assign cfg_eff = clamp_w(cfg_data);
	assign clr     = 13'd1 << eff_w;
	assign cfg_clr = 13'd1 << cfg_eff;
	assign code_x  = {1'b0, code_q};
	assign k_x     = {1'b0, k_q};

	logic stk_full, k_bad, nfc_room, out_free, cfg_we, in_acc;
	assign stk_full = sp_q >= (STK_AW + 1)'(gif_lzw_pkg::STACK_DEPTH);
	assign k_bad    = k_x >= 13'(gif_lzw_pkg::TABLE_ENTRIES);
	assign nfc_room = nfc_q < 13'(gif_lzw_pkg::TABLE_ENTRIES);
	assign out_free = !out_valid_q || !out_stall;

	// Bit extraction step
	logic [3:0]  need, take;
	logic [8:0]  tmask;
	logic [19:0] shifted;
	logic [11:0] partial_nx;
	logic [4:0]  pbits_sum;
	logic        code_done;
	assign need       = width_q - pbits_q;
	assign take       = (held_q < need) ? held_q : need;
	assign tmask      = (9'd1 << take) - 9'd1;
	assign shifted    = {12'd0, bitbuf_q & tmask[7:0]} << pbits_q;
	assign partial_nx = partial_q | shifted[11:0];
	assign pbits_sum  = {1'b0, pbits_q} + {1'b0, take};
	assign code_done  = pbits_sum >= {1'b0, width_q};

	// Control outputs
	logic        dict_we, dict_re, stk_we, stk_re, out_load;
	logic [7:0]  stk_wdata;
	always_comb begin
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		dict_we   = 1'b0;
		dict_re   = 1'b0;
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		stk_wdata = dict_rd_q[7:0];
		out_load  = 1'b0;
		unique case (state_q)
			gif_lzw_pkg::ST_IDLE: begin
				cfg_ready = 1'b1;
				in_stall  = cfg_valid;
			end
			gif_lzw_pkg::ST_CODE: begin
				if (code_x != clr && code_x != clr + 13'd1) begin
					if (after_clear_q) begin
						stk_we    = code_x <= clr + 13'd1;
						stk_wdata = code_q[7:0];
					end else begin
						stk_we    = code_x == nfc_q;
						stk_wdata = first_q;
					end
				end
			end
			gif_lzw_pkg::ST_WALK_RD: begin
				if (k_x >= clr) begin
					dict_re = !(k_bad || stk_full);
				end else if (!stk_full) begin
					stk_we    = 1'b1;
					stk_wdata = k_q[7:0];
					dict_we   = add_q && nfc_room;
				end
			end
			gif_lzw_pkg::ST_WALK_USE: begin
				stk_we    = 1'b1;
				stk_wdata = dict_rd_q[7:0];
			end
			gif_lzw_pkg::ST_POP_RD: stk_re = sp_q != '0;
			gif_lzw_pkg::ST_POP_USE: out_load = (cnt_q == 7'd64) && out_free;
			gif_lzw_pkg::ST_FINAL: out_load = out_free;
			default: ;
		endcase
	end

	assign cfg_we = cfg_valid && cfg_ready;
	assign in_acc = in_valid && !in_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gif_lzw_pkg::ST_IDLE: begin
				if (in_acc && !halted_q)
					state_d = in_data.end_of_input ? gif_lzw_pkg::ST_FINAL
					                               : gif_lzw_pkg::ST_EXTRACT;
			end
			gif_lzw_pkg::ST_EXTRACT: begin
				if (held_q == 4'd0)
					state_d = (cnt_q != 7'd0) ? gif_lzw_pkg::ST_FINAL : gif_lzw_pkg::ST_IDLE;
				else if (code_done)
					state_d = gif_lzw_pkg::ST_CODE;
			end
			gif_lzw_pkg::ST_CODE: begin
				if (code_x == clr + 13'd1) state_d = gif_lzw_pkg::ST_FINAL;
				else if (code_x == clr) state_d = gif_lzw_pkg::ST_EXTRACT;
				else if (after_clear_q)
					state_d = (code_x > clr + 13'd1) ? gif_lzw_pkg::ST_FINAL
					                                 : gif_lzw_pkg::ST_POP_RD;
				else
					state_d = (code_x > nfc_q) ? gif_lzw_pkg::ST_FINAL
					                           : gif_lzw_pkg::ST_WALK_RD;
			end
			gif_lzw_pkg::ST_WALK_RD: begin
				if (k_x >= clr)
					state_d = (k_bad || stk_full) ? gif_lzw_pkg::ST_FINAL
					                              : gif_lzw_pkg::ST_WALK_USE;
				else
					state_d = stk_full ? gif_lzw_pkg::ST_FINAL : gif_lzw_pkg::ST_POP_RD;
			end
			gif_lzw_pkg::ST_WALK_USE: state_d = gif_lzw_pkg::ST_WALK_RD;
			gif_lzw_pkg::ST_POP_RD: begin
				state_d = (sp_q == '0) ? gif_lzw_pkg::ST_EXTRACT : gif_lzw_pkg::ST_POP_USE;
			end
			gif_lzw_pkg::ST_POP_USE: begin
				if (cnt_q != 7'd64) state_d = gif_lzw_pkg::ST_POP_RD;
			end
			gif_lzw_pkg::ST_FINAL: begin
				if (out_free) state_d = gif_lzw_pkg::ST_IDLE;
			end
			default: state_d = gif_lzw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gif_lzw_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Memory ports
	always_ff @(posedge clk) begin
		if (dict_we) dict_mem[nfc_q[TAB_AW-1:0]] <= {prev_q, k_q[7:0]};
		if (dict_re) dict_rd_q <= dict_mem[k_q[TAB_AW-1:0]];
	end

	logic [STK_AW:0] sp_m1;
	assign sp_m1 = sp_q - 1'b1;
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[sp_q[STK_AW-1:0]] <= stk_wdata;
		if (stk_re) stk_rd_q <= stk_mem[sp_m1[STK_AW-1:0]];
	end

	// Decoder datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_w_q       <= gif_lzw_pkg::DEF_MIN_WIDTH;
			nfc_q         <= (13'd1 << gif_lzw_pkg::DEF_MIN_WIDTH) + 13'd2;
			limit_q       <= (13'd2 << gif_lzw_pkg::DEF_MIN_WIDTH) - 13'd1;
			width_q       <= gif_lzw_pkg::DEF_MIN_WIDTH + 4'd1;
			bitbuf_q      <= '0;
			held_q        <= '0;
			partial_q     <= '0;
			pbits_q       <= '0;
			first_q       <= '0;
			prev_q        <= '0;
			after_clear_q <= 1'b1;
			halted_q      <= 1'b0;
			code_q        <= '0;
			incode_q      <= '0;
			k_q           <= '0;
			sp_q          <= '0;
			add_q         <= 1'b0;
			status_q      <= gif_lzw_pkg::STAT_DATA;
			cnt_q         <= '0;
			obuf_q        <= '0;
		end else begin
			if (out_load) begin
				obuf_q <= '0;
				cnt_q  <= '0;
			end
			unique case (state_q)
				gif_lzw_pkg::ST_IDLE: begin
					if (cfg_we) begin
						min_w_q       <= cfg_data;
						nfc_q         <= cfg_clr + 13'd2;
						limit_q       <= (cfg_clr << 1) - 13'd1;
						width_q       <= cfg_eff + 4'd1;
						after_clear_q <= 1'b1;
						bitbuf_q      <= '0;
						held_q        <= '0;
						partial_q     <= '0;
						pbits_q       <= '0;
						first_q       <= '0;
						prev_q        <= '0;
						halted_q      <= 1'b0;
					end else if (in_acc && !halted_q) begin
						status_q <= in_data.end_of_input ? gif_lzw_pkg::STAT_RANOUT
						                                 : gif_lzw_pkg::STAT_DATA;
						bitbuf_q <= in_data.data_byte;
						held_q   <= 4'd8;
					end
				end
				gif_lzw_pkg::ST_EXTRACT: begin
					if (held_q != 4'd0) begin
						bitbuf_q <= bitbuf_q >> take;
						held_q   <= held_q - take;
						if (code_done) begin
							code_q    <= partial_nx;
							partial_q <= '0;
							pbits_q   <= '0;
						end else begin
							partial_q <= partial_nx;
							pbits_q   <= pbits_sum[3:0];
						end
					end
				end
				gif_lzw_pkg::ST_CODE: begin
					if (code_x == clr + 13'd1) begin
						status_q <= gif_lzw_pkg::STAT_END;
					end else if (code_x == clr) begin
						nfc_q         <= clr + 13'd2;
						limit_q       <= (clr << 1) - 13'd1;
						width_q       <= eff_w + 4'd1;
						after_clear_q <= 1'b1;
					end else if (after_clear_q) begin
						if (code_x > clr + 13'd1) begin
							status_q <= gif_lzw_pkg::STAT_BAD;
						end else begin
							first_q       <= code_q[7:0];
							prev_q        <= code_q;
							after_clear_q <= 1'b0;
							sp_q          <= (STK_AW + 1)'(1);
							add_q         <= 1'b0;
						end
					end else if (code_x > nfc_q) begin
						status_q <= gif_lzw_pkg::STAT_BAD;
					end else begin
						incode_q <= code_q;
						add_q    <= 1'b1;
						if (code_x == nfc_q) begin
							sp_q <= (STK_AW + 1)'(1);
							k_q  <= prev_q;
						end else begin
							sp_q <= '0;
							k_q  <= code_q;
						end
					end
				end
				gif_lzw_pkg::ST_WALK_RD: begin
					if (k_x >= clr) begin
						if (k_bad || stk_full) status_q <= gif_lzw_pkg::STAT_BAD;
					end else if (stk_full) begin
						status_q <= gif_lzw_pkg::STAT_BAD;
					end else begin
						sp_q    <= sp_q + 1'b1;
						first_q <= k_q[7:0];
						prev_q  <= incode_q;
						if (nfc_room) begin
							nfc_q <= nfc_q + 13'd1;
							if (nfc_q + 13'd1 > limit_q &&
							    nfc_q + 13'd1 < 13'(gif_lzw_pkg::TABLE_ENTRIES)) begin
								limit_q <= {limit_q[11:0], 1'b1};
								width_q <= width_q + 4'd1;
							end
						end
					end
				end
				gif_lzw_pkg::ST_WALK_USE: begin
					sp_q <= sp_q + 1'b1;
					k_q  <= dict_rd_q[19:8];
				end
				gif_lzw_pkg::ST_POP_RD: begin
					if (sp_q != '0) sp_q <= sp_m1;
				end
				gif_lzw_pkg::ST_POP_USE: begin
					if (cnt_q != 7'd64) begin
						obuf_q[cnt_q[5:0]] <= stk_rd_q;
						cnt_q              <= cnt_q + 7'd1;
					end
				end
				gif_lzw_pkg::ST_FINAL: begin
					if (out_free && status_q != gif_lzw_pkg::STAT_DATA) halted_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.pixels_word0 <= obuf_q[7:0];
			out_q.pixels_word1 <= obuf_q[15:8];
			out_q.pixels_word2 <= obuf_q[23:16];
			out_q.pixels_word3 <= obuf_q[31:24];
			out_q.pixels_word4 <= obuf_q[39:32];
			out_q.pixels_word5 <= obuf_q[47:40];
			out_q.pixels_word6 <= obuf_q[55:48];
			out_q.pixels_word7 <= obuf_q[63:56];
			out_q.byte_count   <= cnt_q;
			out_q.last         <= state_q == gif_lzw_pkg::ST_FINAL;
			out_q.status       <= (state_q == gif_lzw_pkg::ST_FINAL) ? status_q
			                                                         : gif_lzw_pkg::STAT_DATA;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_halt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> state_q == gif_lzw_pkg::ST_IDLE)
		else $error("halted outside idle");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 7'd64)
		else $error("byte buffer overrun");
	a_mid_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last |-> out_q.status == gif_lzw_pkg::STAT_DATA &&
		out_q.byte_count == 7'd64)
		else $error("non-final result not full or has status");
	a_pop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gif_lzw_pkg::ST_POP_USE && cnt_q != 7'd64 |=>
		state_q == gif_lzw_pkg::ST_POP_RD)
		else $error("pop sequence broken");

endmodule

FILE: tb/sv/gif_lzw_checker.sv
// Checker for the GIF LZW decoder: decode predictor, expected-beat queue and compare.
`timescale 1ns / 1ps
module gif_lzw_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  gif_lzw_pkg::in_beat_t  in_data,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  gif_lzw_pkg::out_beat_t out_data,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [3:0]             cfg_data,
	output int                     errors,
	output int                     pending
);

	// Predictor state
	logic [19:0] dict [gif_lzw_pkg::TABLE_ENTRIES];
	logic [7:0]  stk [gif_lzw_pkg::STACK_DEPTH];
	logic [3:0]  min_w;
	int          next_code, limit_code, code_w, acc_code, acc_bits, first_byte, prev_code;
	bit          fresh, halted;
	logic [7:0]  decoded [$];
	gif_lzw_pkg::out_beat_t expect_q [$];

	function automatic int eff_width();
		if (min_w < 4'd2) return 2;
		if (min_w > 4'd8) return 8;
		return min_w;
	endfunction

	function automatic void table_reset();
		next_code  = (1 << eff_width()) + 2;
		limit_code = 2 * (1 << eff_width()) - 1;
		code_w     = eff_width() + 1;
		fresh      = 1'b1;
	endfunction

	function automatic void decoder_init();
		for (int i = 0; i < gif_lzw_pkg::TABLE_ENTRIES; i++) dict[i] = '0;
		acc_code   = 0;
		acc_bits   = 0;
		first_byte = 0;
		prev_code  = 0;
		halted     = 1'b0;
		table_reset();
	endfunction

	// Expand one code into decoded bytes; returns a status code
	function automatic logic [1:0] expand_code(int code);
		int clr, k, sp, incode;
		clr = 1 << eff_width();
		if (code == clr + 1) return gif_lzw_pkg::STAT_END;
		if (code == clr) begin
			table_reset();
			return gif_lzw_pkg::STAT_DATA;
		end
		if (fresh) begin
			if (code > clr + 1) return gif_lzw_pkg::STAT_BAD;
			first_byte = code & 8'hFF;
			prev_code = code;
			if (decoded.size() >= gif_lzw_pkg::RES_BYTES * 64) return gif_lzw_pkg::STAT_BAD;
			decoded.push_back(code[7:0]);
			fresh = 1'b0;
			return gif_lzw_pkg::STAT_DATA;
		end
		incode = code;
		k = code;
		sp = 0;
		// KwKwK: code not yet in table
		if (code >= next_code) begin
			if (code != next_code) return gif_lzw_pkg::STAT_BAD;
			stk[sp] = first_byte[7:0];
			sp++;
			k = prev_code;
		end
		while (k >= clr) begin
			if (k >= gif_lzw_pkg::TABLE_ENTRIES || sp >= gif_lzw_pkg::STACK_DEPTH)
				return gif_lzw_pkg::STAT_BAD;
			stk[sp] = dict[k][7:0];
			sp++;
			k = dict[k][19:8];
		end
		if (sp >= gif_lzw_pkg::STACK_DEPTH) return gif_lzw_pkg::STAT_BAD;
		first_byte = k & 8'hFF;
		stk[sp] = first_byte[7:0];
		sp++;
		while (sp > 0) begin
			sp--;
			if (decoded.size() >= gif_lzw_pkg::RES_BYTES * 64) return gif_lzw_pkg::STAT_BAD;
			decoded.push_back(stk[sp]);
		end
		// New entry, width grows when the limit is passed
		if (next_code < gif_lzw_pkg::TABLE_ENTRIES) begin
			dict[next_code] = {prev_code[11:0], k[7:0]};
			next_code++;
			if (next_code > limit_code && next_code < gif_lzw_pkg::TABLE_ENTRIES) begin
				limit_code = limit_code * 2 + 1;
				code_w++;
			end
		end
		prev_code = incode & 12'hFFF;
		return gif_lzw_pkg::STAT_DATA;
	endfunction

	// Predict the result beats of one accepted input beat
	function automatic void predict_beat(gif_lzw_pkg::in_beat_t b);
		logic [1:0]   status, res;
		bit           ev;
		int           bbuf, bheld, need, take, n, cnt, base;
		logic [511:0] pix;
		gif_lzw_pkg::out_beat_t o;
		if (halted) return;
		decoded.delete();
		status = gif_lzw_pkg::STAT_DATA;
		ev = 1'b0;
		if (b.end_of_input) begin
			status = gif_lzw_pkg::STAT_RANOUT;
			ev = 1'b1;
			halted = 1'b1;
		end else begin
			bbuf = b.data_byte;
			bheld = 8;
			while (bheld > 0) begin
				need = code_w - acc_bits;
				take = (bheld < need) ? bheld : need;
				acc_code = (acc_code | ((bbuf & ((1 << take) - 1)) << acc_bits)) & 12'hFFF;
				bbuf = bbuf >> take;
				bheld -= take;
				acc_bits += take;
				if (acc_bits >= code_w) begin
					n = acc_code;
					acc_code = 0;
					acc_bits = 0;
					res = expand_code(n);
					if (res != gif_lzw_pkg::STAT_DATA) begin
						status = res;
						ev = 1'b1;
						halted = 1'b1;
						break;
					end
				end
			end
		end
		n = (decoded.size() + gif_lzw_pkg::RES_BYTES - 1) / gif_lzw_pkg::RES_BYTES;
		if (ev && n == 0) n = 1;
		for (int r = 0; r < n; r++) begin
			base = r * gif_lzw_pkg::RES_BYTES;
			cnt = decoded.size() > base ? decoded.size() - base : 0;
			if (cnt > gif_lzw_pkg::RES_BYTES) cnt = gif_lzw_pkg::RES_BYTES;
			pix = '0;
			for (int i = 0; i < cnt; i++) pix[i*8 +: 8] = decoded[base + i];
			o.pixels_word0 = pix[63:0];
			o.pixels_word1 = pix[127:64];
			o.pixels_word2 = pix[191:128];
			o.pixels_word3 = pix[255:192];
			o.pixels_word4 = pix[319:256];
			o.pixels_word5 = pix[383:320];
			o.pixels_word6 = pix[447:384];
			o.pixels_word7 = pix[511:448];
			o.byte_count = cnt[6:0];
			o.status = (r == n - 1) ? status : gif_lzw_pkg::STAT_DATA;
			o.last = (r == n - 1);
			expect_q.push_back(o);
		end
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [63:0] word_of(gif_lzw_pkg::out_beat_t o, int w);
		logic [511:0] all;
		all = o[521:10];
		return all[(7 - w) * 64 +: 64];
	endfunction

	// Watch cfg, input and result beats
	always @(posedge clk or negedge arst_n) begin
		gif_lzw_pkg::out_beat_t want;
		if (!arst_n) begin
			min_w = gif_lzw_pkg::DEF_MIN_WIDTH;
			decoder_init();
			expect_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				min_w = cfg_data;
				decoder_init();
			end
			if (in_valid && !in_stall) predict_beat(in_data);
			if (out_valid && !out_stall) begin
				if (expect_q.size() == 0) begin
					report("unexpected beat", 64'(out_data.byte_count), 64'd0);
				end else begin
					want = expect_q.pop_front();
					for (int w = 0; w < 8; w++)
						if (word_of(out_data, w) !== word_of(want, w))
							report($sformatf("pixels_word%0d", w), word_of(out_data, w),
								word_of(want, w));
					if (out_data.byte_count !== want.byte_count)
						report("byte_count", 64'(out_data.byte_count), 64'(want.byte_count));
					if (out_data.status !== want.status)
						report("status", 64'(out_data.status), 64'(want.status));
					if (out_data.last !== want.last)
						report("last", 64'(out_data.last), 64'(want.last));
				end
			end
			pending = expect_q.size();
		end
	end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the GIF LZW decoder: code stream stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE      = 1000;

	// Stream endings
	typedef enum int { END_CODE, END_INPUT, END_BAD, END_NOISE } ending_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	gif_lzw_pkg::in_beat_t  in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	gif_lzw_pkg::out_beat_t out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_data = '0;
	int         errors, pending;
	int         cycles = 0;
	int         idle_pct = 0, stall_pct = 0;
	int         sent = 0;

	// Encoder-side mirror of the code width
	int         g_clr, g_next, g_limit, g_w;
	bit         g_fresh;
	logic [31:0] g_acc;
	int         g_nbits;

	gif_lzw_decoder_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	gif_lzw_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Cycle counter and timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver stall
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	task automatic set_phase(int p);
		case (p % 4)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 59; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 59; end
			default: begin idle_pct = 24; stall_pct = 24; end
		endcase
	endtask

	task automatic send_beat(logic [7:0] d, bit eoi);
		gif_lzw_pkg::in_beat_t b;
		b.data_byte = d;
		b.end_of_input = eoi;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Wait until every expected result is in, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_cfg(logic [3:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void enc_reset_table();
		g_next  = g_clr + 2;
		g_limit = 2 * g_clr - 1;
		g_w     = $clog2(g_clr) + 1;
		g_fresh = 1'b1;
	endfunction

	// Pack one code LSB first and follow the decoder's width growth
	task automatic put_code(int c);
		g_acc = g_acc | (c << g_nbits);
		g_nbits += g_w;
		while (g_nbits >= 8) begin
			send_beat(g_acc[7:0], 1'b0);
			g_acc = g_acc >> 8;
			g_nbits -= 8;
		end
		if (c == g_clr) enc_reset_table();
		else if (c == g_clr + 1) ;
		else if (g_fresh) g_fresh = 1'b0;
		else if (g_next < gif_lzw_pkg::TABLE_ENTRIES) begin
			g_next++;
			if (g_next > g_limit && g_next < gif_lzw_pkg::TABLE_ENTRIES) begin
				g_limit = g_limit * 2 + 1;
				g_w++;
			end
		end
	endtask

	// Pad the last partial byte with random bits
	task automatic flush_bits();
		logic [7:0] pad;
		pad = 8'($urandom);
		if (g_nbits > 0) send_beat(8'((g_acc[7:0] & ((8'd1 << g_nbits) - 8'd1)) |
			(pad << g_nbits)), 1'b0);
		g_acc = 0;
		g_nbits = 0;
	endtask

	// One well-formed stream of random codes, then the chosen ending
	task automatic run_stream(logic [3:0] mw, int ncodes, ending_t ending, bit hold_mid);
		int ew, c, top;
		ew = (mw < 2) ? 2 : (mw > 8) ? 8 : mw;
		g_clr = 1 << ew;
		g_acc = 0;
		g_nbits = 0;
		enc_reset_table();
		if ($urandom_range(1)) put_code(g_clr);
		for (int i = 0; i < ncodes; i++) begin
			if (hold_mid && i == ncodes / 2) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			if (g_fresh) c = $urandom_range(g_clr - 1);
			else if ($urandom_range(99) < 2) c = g_clr;
			else if ($urandom_range(99) < 20) c = g_next;
			else begin
				c = $urandom_range(g_next);
				if (c == g_clr + 1) c = g_clr - 1;
			end
			if (c >= (1 << g_w)) c = g_clr - 1;
			put_code(c);
		end
		top = (1 << g_w) - 1;
		case (ending)
			END_CODE: begin
				put_code(g_clr + 1);
				flush_bits();
			end
			END_INPUT: begin
				flush_bits();
				send_beat(8'($urandom), 1'b1);
			end
			END_BAD: begin
				if (g_fresh) put_code($urandom_range(top, g_clr + 2));
				else if (g_next + 1 <= top) put_code($urandom_range(top, g_next + 1));
				else put_code(g_clr + 1);
				flush_bits();
			end
			default: begin
				flush_bits();
				repeat ($urandom_range(6, 2)) send_beat(8'($urandom), 1'b0);
			end
		endcase
		// Beats after a halt are dropped
		send_beat(8'($urandom), 1'b0);
		send_beat(8'($urandom), 1'b1);
		drain();
	endtask

	initial begin
		int s;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset width, extremes, out-of-range widths, every ending
		run_stream(4'd8, 6, END_CODE, 1'b0);
		write_cfg(4'd2);
		run_stream(4'd2, 12, END_CODE, 1'b0);
		write_cfg(4'd0);
		run_stream(4'd0, 0, END_BAD, 1'b0);
		write_cfg(4'd15);
		run_stream(4'd15, 5, END_INPUT, 1'b0);
		write_cfg(4'd1);
		run_stream(4'd1, 4, END_NOISE, 1'b0);
		write_cfg(4'd8);
		run_stream(4'd8, 4, END_BAD, 1'b0);

		// Long stream at the narrowest width, code width grows several steps
		write_cfg(4'd2);
		run_stream(4'd2, 150, END_CODE, 1'b0);

		// Random streams over all idling phases
		s = 0;
		while (sent < 360) begin
			logic [3:0] mw;
			mw = 4'($urandom_range(15));
			set_phase(s);
			write_cfg(mw);
			run_stream(mw, $urandom_range(30, 5), ending_t'($urandom_range(3)), s == 5);
			s++;
		end
		set_phase(0);
		drain();
		if (errors == 0 && pending == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
